FILE: hdl/sfd_pkg.sv
// Shared types and constants of the stuffed frame deframer.
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

    localparam int MAX_FRAME_BYTES = 4096;
    // Decoded byte count saturates at MAX_FRAME_BYTES + 1
    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 2);

    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEADER   = 2'd0,
        REG_TRAILER  = 2'd1,
        REG_ESCAPE   = 2'd2,
        REG_ESC_OFFS = 2'd3
    } cfg_reg_t;

    localparam logic [BYTE_W-1:0] HEADER_RST   = 8'hcc;
    localparam logic [BYTE_W-1:0] TRAILER_RST  = 8'hdd;
    localparam logic [BYTE_W-1:0] ESCAPE_RST   = 8'hee;
    localparam logic [BYTE_W-1:0] ESC_OFFS_RST = 8'hcc;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SUM_BAD  = 3'd1,
        ST_BAD_ESC  = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_ABORTED  = 3'd4,
        ST_TOO_LONG = 3'd5
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] header_byte;
        logic [BYTE_W-1:0] trailer_byte;
        logic [BYTE_W-1:0] escape_byte;
        logic [BYTE_W-1:0] escape_offset;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              frame_end;
        status_t           frame_status;
    } result_t;

endpackage

`default_nettype wire

FILE: hdl/sfd_if.sv
// Channel interfaces: raw byte input and decoded result output.
`timescale 1ns / 1ps
`default_nettype none

interface sfd_byte_if import sfd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_result_if import sfd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              frame_end;
    status_t           frame_status;

    modport source (output valid, output data_byte, output frame_end, output frame_status,
                    input ready);
    modport sink   (input valid, input data_byte, input frame_end, input frame_status,
                    output ready);
endinterface

`default_nettype wire

FILE: hdl/stuffed_frame_deframer_core.sv
// Byte-stuffed frame deframer with additive check byte: top level.
//
// din carries one raw line byte per transaction (valid/ready). dout carries
// one result per transaction: a payload byte (frame_end low, status ok) or an
// end-of-frame marker (frame_end high, data zero) with the frame status.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata) for the
// header, trailer and escape values and the escape offset; write it only
// while the block is idle.
// Each accepted byte is latched into an input register, decoded against the
// frame state and its result, if any, written to a two-entry output buffer
// whose head drives dout; the byte waits in the input register while that
// buffer is full. One byte per cycle is taken continuously while dout
// drains.
// Payload bytes appear one byte late, since the newest decoded byte is held
// back as the candidate check byte.
// When dout stalls, din.ready drops once the output buffer holds two results
// and one more byte waits in the input register; nothing is lost.
// Reset restores the default framing values and leaves the block out of frame
// with empty buffers.
`timescale 1ns / 1ps
`default_nettype none

module stuffed_frame_deframer_core import sfd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    sfd_byte_if.sink                  din,
    sfd_result_if.source              dout,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_wdata
);

    cfg_t    cfg;
    logic    space;
    logic    push;
    result_t push_res;

    sfd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    sfd_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .din      (din),
        .cfg      (cfg),
        .space    (space),
        .push     (push),
        .push_res (push_res)
    );

    sfd_out_buf u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_res (push_res),
        .space    (space),
        .dout     (dout)
    );

    // Input only backs up when the output buffer is full
    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !din.ready |-> dout.valid)
        else $error("din stalled with no result pending");

    a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid && !dout.frame_end |-> dout.frame_status == ST_OK)
        else $error("payload result with non-ok status");

    a_end_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid && dout.frame_end |-> dout.data_byte == '0)
        else $error("end result with non-zero data");

endmodule

`default_nettype wire

FILE: hdl/sfd_cfg_regs.sv
// Configuration registers: framing byte values and escape offset.
`timescale 1ns / 1ps
`default_nettype none

module sfd_cfg_regs import sfd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_wdata,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_byte   <= HEADER_RST;
            cfg_reg.trailer_byte  <= TRAILER_RST;
            cfg_reg.escape_byte   <= ESCAPE_RST;
            cfg_reg.escape_offset <= ESC_OFFS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_HEADER:   cfg_reg.header_byte   <= cfg_wdata[BYTE_W-1:0];
                REG_TRAILER:  cfg_reg.trailer_byte  <= cfg_wdata[BYTE_W-1:0];
                REG_ESCAPE:   cfg_reg.escape_byte   <= cfg_wdata[BYTE_W-1:0];
                REG_ESC_OFFS: cfg_reg.escape_offset <= cfg_wdata[BYTE_W-1:0];
                default:      ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: hdl/sfd_decode.sv
// Input register, frame state and per-byte decode producing at most one result.
`timescale 1ns / 1ps
`default_nettype none

module sfd_decode import sfd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    sfd_byte_if.sink   din,
    input  wire cfg_t  cfg,
    input  wire logic  space,
    output logic       push,
    output result_t    push_res
);

    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;

    logic              in_frame_reg,    in_frame_next;
    logic              esc_pend_reg,    esc_pend_next;
    logic              held_valid_reg,  held_valid_next;
    logic [BYTE_W-1:0] held_byte_reg,   held_byte_next;
    logic [BYTE_W-1:0] sum_reg,         sum_next;
    logic [CNT_W-1:0]  count_reg,       count_next;

    logic              advance;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] decoded;
    logic              too_long;

    assign advance   = s1_valid_reg && space;
    assign din.ready = !s1_valid_reg || space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (din.valid && din.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (din.valid && din.ready)
        begin
            s1_byte_reg <= din.rx_byte;
        end
    end

    assign b        = s1_byte_reg;
    assign decoded  = esc_pend_reg ? b + cfg.escape_offset : b;
    assign too_long = count_reg > CNT_W'(MAX_FRAME_BYTES);

    always_comb
    begin
        in_frame_next   = in_frame_reg;
        esc_pend_next   = esc_pend_reg;
        held_valid_next = held_valid_reg;
        held_byte_next  = held_byte_reg;
        sum_next        = sum_reg;
        count_next      = count_reg;
        push            = 1'b0;
        push_res        = '{data_byte: '0, frame_end: 1'b0, frame_status: ST_OK};

        if (advance)
        begin
            if (b == cfg.header_byte)
            begin
                // Header always (re)opens; inside a frame the old one is aborted
                if (in_frame_reg)
                begin
                    push                  = 1'b1;
                    push_res.frame_end    = 1'b1;
                    push_res.frame_status = ST_ABORTED;
                end
                in_frame_next   = 1'b1;
                esc_pend_next   = 1'b0;
                held_valid_next = 1'b0;
                held_byte_next  = '0;
                sum_next        = '0;
                count_next      = '0;
            end
            else if (!in_frame_reg)
            begin
                // ignored outside a frame
            end
            else if (b == cfg.trailer_byte)
            begin
                push               = 1'b1;
                push_res.frame_end = 1'b1;
                if (esc_pend_reg)
                    push_res.frame_status = ST_BAD_ESC;
                else if (!held_valid_reg)
                    push_res.frame_status = ST_EMPTY;
                else if (too_long)
                    push_res.frame_status = ST_TOO_LONG;
                else if (sum_reg != held_byte_reg)
                    push_res.frame_status = ST_SUM_BAD;
                else
                    push_res.frame_status = ST_OK;
                in_frame_next   = 1'b0;
                esc_pend_next   = 1'b0;
                held_valid_next = 1'b0;
                held_byte_next  = '0;
                sum_next        = '0;
                count_next      = '0;
            end
            else if (esc_pend_reg || b != cfg.escape_byte)
            begin
                // Decoded byte: release the held one, hold back the new one
                esc_pend_next = 1'b0;
                if (held_valid_reg)
                begin
                    push               = 1'b1;
                    push_res.data_byte = held_byte_reg;
                    sum_next           = sum_reg + held_byte_reg;
                end
                held_byte_next  = decoded;
                held_valid_next = 1'b1;
                if (!too_long)
                    count_next = count_reg + 1'b1;
            end
            else
            begin
                esc_pend_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            esc_pend_reg   <= 1'b0;
            held_valid_reg <= 1'b0;
            held_byte_reg  <= '0;
            sum_reg        <= '0;
            count_reg      <= '0;
        end
        else
        begin
            in_frame_reg   <= in_frame_next;
            esc_pend_reg   <= esc_pend_next;
            held_valid_reg <= held_valid_next;
            held_byte_reg  <= held_byte_next;
            sum_reg        <= sum_next;
            count_reg      <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sfd_out_buf.sv
// Two-entry output register with skid slot; space flag is registered-only.
`timescale 1ns / 1ps
`default_nettype none

module sfd_out_buf import sfd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_res,
    output logic         space,
    sfd_result_if.source dout
);

    logic [1:0] cnt_reg;
    result_t    e0_reg;
    result_t    e1_reg;
    logic       pop;

    assign pop   = dout.valid && dout.ready;
    assign space = cnt_reg != 2'd2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (cnt_reg == 2'd2)
            begin
                e0_reg <= e1_reg;
                if (push)
                    e1_reg <= push_res;
            end
            else if (push)
            begin
                e0_reg <= push_res;
            end
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0)
                e0_reg <= push_res;
            else
                e1_reg <= push_res;
        end
    end

    assign dout.valid        = cnt_reg != 2'd0;
    assign dout.data_byte    = e0_reg.data_byte;
    assign dout.frame_end    = e0_reg.frame_end;
    assign dout.frame_status = e0_reg.frame_status;

endmodule

`default_nettype wire
